// ===== hdl/ligc_pkg.sv =====
// Shared types and constants for the linear index / grid converter.
package ligc_pkg;

  localparam int unsigned MaxRank   = 4;
  localparam int unsigned DimBits   = 16;
  localparam int unsigned IndexBits = 32;
  localparam int unsigned RankBits  = 3;
  localparam int unsigned CfgAddrBits = 3;
  localparam int unsigned DivStages = MaxRank * IndexBits;
  localparam int unsigned ProdBits  = IndexBits + DimBits;

  localparam logic [CfgAddrBits-1:0] RegGridRank = 3'd0;
  localparam logic [CfgAddrBits-1:0] RegDim0     = 3'd1;
  localparam logic [CfgAddrBits-1:0] RegDim1     = 3'd2;
  localparam logic [CfgAddrBits-1:0] RegDim2     = 3'd3;
  localparam logic [CfgAddrBits-1:0] RegDim3     = 3'd4;

  localparam logic OpIndexToGrid = 1'b0;
  localparam logic OpGridToIndex = 1'b1;

  typedef struct packed {
    logic                              op;
    logic                              bad;
    logic [RankBits-1:0]               rank;
    logic [IndexBits-1:0]              num;
    logic [DimBits-1:0]                rem;
    logic [MaxRank-1:0][DimBits-1:0]   crd;
    logic [DimBits-1:0]                x;
    logic [DimBits-1:0]                y;
    logic [DimBits-1:0]                z;
    logic [2*DimBits-1:0]              slice;
    logic [2*DimBits-1:0]              yoff;
    logic [ProdBits-1:0]               zoff;
    logic [IndexBits-1:0]              idx;
  } pipe_t;

endpackage

// ===== hdl/linear_index_grid_converter.sv =====
// Top level: pipelined converter between column-major linear indices and grid coordinates.
//
// Converts 1-based column-major linear indices to up to four grid coordinates
// (operation 0) and three coordinates back to a linear index (operation 1).
// One beat is accepted every cycle while the output is not stalled; each beat
// yields one result beat. The pipeline depth is set by the division chain:
// one restoring divide step per stage, one full-width quotient per dimension.
// Out-of-grid inputs return all-zero fields with the out_of_range flag in
// m_axis_tuser. Configuration writes are taken at any time but must only be
// issued while no beat is in flight.
module linear_index_grid_converter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ligc_pkg::CfgAddrBits-1:0]    cfg_addr_i,
  input  logic [ligc_pkg::DimBits-1:0]        cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] linear_index, [47:32] coord_x, [63:48] coord_y, [79:64] coord_z
  input  logic [79:0]                         s_axis_tdata,
  // [0] operation
  input  logic                                s_axis_tuser,
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] grid_c0, [31:16] grid_c1, [47:32] grid_c2, [63:48] grid_c3,
  // [95:64] index_result
  output logic [95:0]                         m_axis_tdata,
  // [0] out_of_range
  output logic                                m_axis_tuser
);

  localparam int unsigned NS = ligc_pkg::DivStages;
  localparam int unsigned IB = ligc_pkg::IndexBits;
  localparam int unsigned DB = ligc_pkg::DimBits;
  localparam int unsigned MR = ligc_pkg::MaxRank;

  // configuration registers
  logic [ligc_pkg::RankBits-1:0] rank_q;
  logic [MR-1:0][DB-1:0]         dim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= ligc_pkg::RankBits'(3);
      dim_q  <= {MR{DB'(1)}};
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        ligc_pkg::RegGridRank: rank_q   <= cfg_data_i[ligc_pkg::RankBits-1:0];
        ligc_pkg::RegDim0:     dim_q[0] <= cfg_data_i;
        ligc_pkg::RegDim1:     dim_q[1] <= cfg_data_i;
        ligc_pkg::RegDim2:     dim_q[2] <= cfg_data_i;
        ligc_pkg::RegDim3:     dim_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline
  ligc_pkg::pipe_t st_q [NS+1];
  ligc_pkg::pipe_t st_d [NS+1];
  logic [NS:0]     vld_q;
  logic            out_vld_q;
  logic [95:0]     out_data_q;
  logic            out_bad_q;
  logic            en;
  logic            res_bad;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // input stage: range checks, index minus one, effective rank
  always_comb begin
    logic [DB-1:0] x, y, z;
    logic [IB-1:0] li;
    x = s_axis_tdata[47:32];
    y = s_axis_tdata[63:48];
    z = s_axis_tdata[79:64];
    li = s_axis_tdata[31:0];
    st_d[0]      = '0;
    st_d[0].op   = s_axis_tuser;
    st_d[0].x    = x;
    st_d[0].y    = y;
    st_d[0].z    = z;
    if (rank_q == '0) st_d[0].rank = ligc_pkg::RankBits'(1);
    else if (rank_q > ligc_pkg::RankBits'(MR)) st_d[0].rank = ligc_pkg::RankBits'(MR);
    else st_d[0].rank = rank_q;
    if (s_axis_tuser == ligc_pkg::OpIndexToGrid) begin
      st_d[0].bad = (li == '0);
      st_d[0].num = li - IB'(1);
    end else begin
      st_d[0].bad = (x == '0) || (x > dim_q[0]) || (y == '0) || (y > dim_q[1]) ||
                    (z == '0) || (z > dim_q[2]);
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int unsigned J    = s / IB;
    localparam int unsigned STEP = s % IB;
    always_comb begin
      logic [DB:0]       rem_s;
      logic              ge;
      logic              act;
      logic [ligc_pkg::ProdBits:0] sum;
      st_d[s+1] = st_q[s];
      act   = (st_q[s].op == ligc_pkg::OpIndexToGrid) && !st_q[s].bad &&
              (ligc_pkg::RankBits'(J) < st_q[s].rank);
      rem_s = {st_q[s].rem, st_q[s].num[IB-1]};
      ge    = (rem_s >= {1'b0, dim_q[J]});
      sum   = '0;
      if (act) begin
        if (dim_q[J] == '0) begin
          st_d[s+1].bad = 1'b1;
        end else begin
          st_d[s+1].num = {st_q[s].num[IB-2:0], ge};
          st_d[s+1].rem = ge ? DB'(rem_s - {1'b0, dim_q[J]}) : rem_s[DB-1:0];
          if (STEP == IB - 1) begin
            st_d[s+1].crd[J] = st_d[s+1].rem + DB'(1);
            st_d[s+1].rem    = '0;
          end
        end
      end
      // grid to index arithmetic rides along the first stages
      if (s == 0) begin
        st_d[s+1].slice = dim_q[0] * dim_q[1];
        st_d[s+1].yoff  = DB'(st_q[s].y - DB'(1)) * dim_q[0];
      end else if (s == 1) begin
        st_d[s+1].zoff = st_q[s].slice * DB'(st_q[s].z - DB'(1));
      end else if (s == 2) begin
        sum = {1'b0, st_q[s].zoff} + (ligc_pkg::ProdBits+1)'(st_q[s].yoff) +
              (ligc_pkg::ProdBits+1)'(st_q[s].x);
        if (st_q[s].op == ligc_pkg::OpGridToIndex && !st_q[s].bad) begin
          if (sum[ligc_pkg::ProdBits:IB] != '0) st_d[s+1].bad = 1'b1;
          else st_d[s+1].idx = sum[IB-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NS-1:0], s_axis_tvalid};
      out_vld_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int unsigned k = 0; k <= NS; k++) st_q[k] <= st_d[k];
    end
  end

  // result stage: a quotient left over means the index lies past the grid
  assign res_bad = st_q[NS].bad ||
                   (st_q[NS].op == ligc_pkg::OpIndexToGrid && st_q[NS].num != '0);

  always_comb begin
    m_axis_tvalid = out_vld_q;
    m_axis_tdata  = out_data_q;
    m_axis_tuser  = out_bad_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_bad_q <= res_bad;
      if (res_bad) begin
        out_data_q <= '0;
      end else if (st_q[NS].op == ligc_pkg::OpIndexToGrid) begin
        out_data_q <= {32'd0, st_q[NS].crd};
      end else begin
        out_data_q <= {st_q[NS].idx, 64'd0};
      end
    end
  end

endmodule

// ===== bench/ligc_checker.sv =====
// Stream monitor and result predictor for the index/grid converter.
module ligc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [79:0] in_data_i,
  input  logic        in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [95:0] out_data_i,
  input  logic        out_user_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] c0, c1, c2, c3;
    logic [31:0] idx;
    logic        oor;
  } conv_result_t;

  logic [2:0]  rank_q;
  logic [15:0] dims_q [4];
  conv_result_t result_q [$];

  function automatic conv_result_t convert(logic op, logic [79:0] d);
    conv_result_t r;
    logic [63:0] rest, x, y, z, v, dim;
    int unsigned rank;
    r = '0;
    if (op == ligc_pkg::OpIndexToGrid) begin
      rank = (rank_q < 3'd1) ? 1 : (rank_q > 3'd4) ? 4 : 32'(rank_q);
      rest = 64'(d[31:0]);
      if (rest == 64'd0) begin
        r.oor = 1'b1;
      end else begin
        rest = rest - 64'd1;
        for (int j = 0; j < rank; j++) begin
          dim = 64'(dims_q[j]);
          if (!r.oor) begin
            if (dim == 64'd0) begin
              r.oor = 1'b1;
            end else begin
              case (j)
                0: r.c0 = 16'(rest % dim + 64'd1);
                1: r.c1 = 16'(rest % dim + 64'd1);
                2: r.c2 = 16'(rest % dim + 64'd1);
                default: r.c3 = 16'(rest % dim + 64'd1);
              endcase
              rest = rest / dim;
            end
          end
        end
        if (rest != 64'd0) r.oor = 1'b1;
      end
    end else begin
      x = 64'(d[47:32]);
      y = 64'(d[63:48]);
      z = 64'(d[79:64]);
      if (x < 64'd1 || x > 64'(dims_q[0]) || y < 64'd1 || y > 64'(dims_q[1]) ||
          z < 64'd1 || z > 64'(dims_q[2])) begin
        r.oor = 1'b1;
      end else begin
        // products stay below 2^64 for 16-bit operands
        v = 64'(dims_q[0]) * 64'(dims_q[1]) * (z - 64'd1) +
            (y - 64'd1) * 64'(dims_q[0]) + x;
        if (v > 64'hFFFF_FFFF) r.oor = 1'b1;
        else r.idx = v[31:0];
      end
    end
    if (r.oor) begin
      r.c0 = '0; r.c1 = '0; r.c2 = '0; r.c3 = '0; r.idx = '0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    conv_result_t got, want;
    if (!rst_ni) begin
      rank_q <= 3'd3;
      for (int i = 0; i < 4; i++) dims_q[i] <= 16'd1;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_addr_i == ligc_pkg::RegGridRank) rank_q <= cfg_data_i[2:0];
        else if (cfg_addr_i inside {ligc_pkg::RegDim0, ligc_pkg::RegDim1,
                                    ligc_pkg::RegDim2, ligc_pkg::RegDim3})
          dims_q[2'(cfg_addr_i - ligc_pkg::RegDim0)] <= cfg_data_i;
      end
      if (in_valid_i && in_ready_i) result_q.push_back(convert(in_user_i, in_data_i));
      if (out_valid_i && out_ready_i) begin
        got = {out_data_i[15:0], out_data_i[31:16], out_data_i[47:32], out_data_i[63:48],
               out_data_i[95:64], out_user_i};
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = result_q.pop_front();
          if (got != want) begin
            fail_count_o <= fail_count_o + 1;
            if (got.c0 != want.c0) $error("grid_c0 exp %0d got %0d", want.c0, got.c0);
            if (got.c1 != want.c1) $error("grid_c1 exp %0d got %0d", want.c1, got.c1);
            if (got.c2 != want.c2) $error("grid_c2 exp %0d got %0d", want.c2, got.c2);
            if (got.c3 != want.c3) $error("grid_c3 exp %0d got %0d", want.c3, got.c3);
            if (got.idx != want.idx)
              $error("index_result exp %0d got %0d", want.idx, got.idx);
            if (got.oor != want.oor)
              $error("out_of_range exp %0d got %0d", want.oor, got.oor);
          end
        end
      end
    end
  end

  assign pending_o = result_q.size();
endmodule

// ===== bench/tb_top.sv =====
// Testbench top: clock, reset, stimulus and verdict for the index/grid converter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = ligc_pkg::DivStages + 2;
  localparam int CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [79:0] in_data = '0;
  logic        in_user = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [95:0] out_data;
  logic        out_user;
  int          fail_count, pending;
  int          cycles = 0;
  bit          hold_off = 1'b0;
  bit          no_stall = 1'b0;
  logic [15:0] dim_sz [4];

  always #5 clk_i = ~clk_i;

  linear_index_grid_converter u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_addr_i(cfg_addr), .cfg_data_i(cfg_data),
    .s_axis_tvalid(in_valid), .s_axis_tready(in_ready),
    .s_axis_tdata(in_data), .s_axis_tuser(in_user),
    .m_axis_tvalid(out_valid), .m_axis_tready(out_ready),
    .m_axis_tdata(out_data), .m_axis_tuser(out_user)
  );

  ligc_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_addr_i(cfg_addr), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .in_data_i(in_data), .in_user_i(in_user),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_data_i(out_data), .out_user_i(out_user),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall pattern, a long hold-off, and calm stretches
  always @(negedge clk_i) begin
    if (hold_off) out_ready <= 1'b0;
    else if (no_stall) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic write_reg(logic [2:0] addr, logic [15:0] val);
    cfg_addr  <= addr;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    if (addr != ligc_pkg::RegGridRank) dim_sz[2'(addr - ligc_pkg::RegDim0)] = val;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
  endtask

  // sender: one beat, then maybe a gap; valid held high across back-to-back beats
  task automatic send(logic op, logic [31:0] lin, logic [15:0] x, y, z, bit gap);
    in_user  <= op;
    in_data  <= {z, y, x, lin};
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    if (gap) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  function automatic logic [15:0] pick_dim(logic [15:0] d);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return d + 16'd1;
    if (r == 2 || d == 0) return 16'($urandom);
    return 16'($urandom_range(1, d));
  endfunction

  task automatic random_phase(int n);
    logic [63:0] total;
    int burst;
    total = 64'(dim_sz[0]) * 64'(dim_sz[1]) * 64'(dim_sz[2]) * 64'(dim_sz[3]);
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) burst = $urandom_range(1, 20);
      burst--;
      if ($urandom_range(0, 1))
        send(ligc_pkg::OpGridToIndex, $urandom, pick_dim(dim_sz[0]), pick_dim(dim_sz[1]),
             pick_dim(dim_sz[2]), burst == 0);
      else if ($urandom_range(0, 4) == 0 || total == 0)
        send(ligc_pkg::OpIndexToGrid, $urandom, 16'($urandom), 16'($urandom),
             16'($urandom), burst == 0);
      else
        send(ligc_pkg::OpIndexToGrid,
             32'($urandom_range(1, (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
             : 32'(total + 64'd1))), 16'($urandom), 16'($urandom), 16'($urandom),
             burst == 0);
    end
    in_valid <= 1'b0;
  endtask

  task automatic set_grid(logic [2:0] rank, logic [15:0] d0, d1, d2, d3);
    write_reg(ligc_pkg::RegGridRank, 16'(rank));
    write_reg(ligc_pkg::RegDim0, d0);
    write_reg(ligc_pkg::RegDim1, d1);
    write_reg(ligc_pkg::RegDim2, d2);
    write_reg(ligc_pkg::RegDim3, d3);
  endtask

  initial begin
    for (int i = 0; i < 4; i++) dim_sz[i] = 16'd1;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed beats on a 4x3x2x5 grid
    no_stall = 1'b1;
    set_grid(3'd4, 16'd4, 16'd3, 16'd2, 16'd5);
    send(ligc_pkg::OpIndexToGrid, 32'd0, '0, '0, '0, 1'b0);
    send(ligc_pkg::OpIndexToGrid, 32'd1, '0, '0, '0, 1'b0);
    send(ligc_pkg::OpIndexToGrid, 32'd120, '0, '0, '0, 1'b0);
    send(ligc_pkg::OpIndexToGrid, 32'd121, '0, '0, '0, 1'b0);
    send(ligc_pkg::OpIndexToGrid, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send(ligc_pkg::OpIndexToGrid, 32'd57, '0, '0, '0, 1'b0);
    send(ligc_pkg::OpGridToIndex, '0, 16'd1, 16'd1, 16'd1, 1'b0);
    send(ligc_pkg::OpGridToIndex, '0, 16'd4, 16'd3, 16'd2, 1'b0);
    send(ligc_pkg::OpGridToIndex, '0, 16'd0, 16'd1, 16'd1, 1'b0);
    send(ligc_pkg::OpGridToIndex, '0, 16'd5, 16'd1, 16'd1, 1'b0);
    send(ligc_pkg::OpGridToIndex, '0, 16'd1, 16'd4, 16'd1, 1'b0);
    send(ligc_pkg::OpGridToIndex, '0, 16'd1, 16'd1, 16'd3, 1'b0);
    send(ligc_pkg::OpGridToIndex, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    drain();
    // rank zero, rank too large, zero extent, index too wide
    set_grid(3'd0, 16'd7, 16'd0, 16'd1, 16'd1);
    send(ligc_pkg::OpIndexToGrid, 32'd7, '0, '0, '0, 1'b0);
    send(ligc_pkg::OpIndexToGrid, 32'd8, '0, '0, '0, 1'b0);
    send(ligc_pkg::OpGridToIndex, '0, 16'd1, 16'd1, 16'd1, 1'b1);
    drain();
    set_grid(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(ligc_pkg::OpIndexToGrid, 32'hFFFF_FFFF, '0, '0, '0, 1'b0);
    send(ligc_pkg::OpIndexToGrid, 32'h8000_0000, '0, '0, '0, 1'b0);
    send(ligc_pkg::OpGridToIndex, '0, 16'hFFFF, 16'hFFFF, 16'd1, 1'b0);
    send(ligc_pkg::OpGridToIndex, '0, 16'd1, 16'd1, 16'd2, 1'b0);
    send(ligc_pkg::OpGridToIndex, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    drain();
    no_stall = 1'b0;

    // long receiver hold-off while the sender keeps pushing
    hold_off = 1'b1;
    fork
      begin
        repeat (Latency + 300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(250);
    join
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_grid(3'd1, 16'hFFFF, 16'd3, 16'd1, 16'd1);
        1: set_grid(3'd2, 16'd1, 16'hFFFF, 16'd9, 16'd1);
        2: set_grid(3'd3, 16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                    16'($urandom_range(1, 40)), 16'd2);
        3: set_grid(3'd4, 16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
                    16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)));
        4: set_grid(3'd5, 16'h8000, 16'h8000, 16'd1, 16'd3);
        default: set_grid(3'd4, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      no_stall = (p == 2);
      random_phase(110);
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
